>>> rtl/ttalloc_pkg.sv
// Shared types and constants for the transaction tag allocator.
// Used by ttalloc_freelist and transaction_tag_allocator_top; no dependencies.
`default_nettype none

package ttalloc_pkg;

  // fixed field widths
  localparam int TAG_W    = 8;
  localparam int RES_W    = 8;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // default tag space size
  localparam int TAG_SPACE_DEF = 256;

  // item operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_RESP    = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_NOT_PENDING = 2'd2,
    ST_WRONG_RES   = 2'd3
  } status_t;

  // free list update for one item
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [TAG_W-1:0] push_tag;
  } fl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/ttalloc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ttalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ttalloc_freelist.sv
// Free tag FIFO: storage RAM, head/tail pointers, fill count.
// Depends on ttalloc_pkg and ttalloc_ram.
`default_nettype none

module ttalloc_freelist #(
  parameter int TAG_SPACE = ttalloc_pkg::TAG_SPACE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire ttalloc_pkg::fl_cmd_t          cmd,
  output logic      [ttalloc_pkg::TAG_W-1:0] head_tag,
  output logic                               empty
);

  localparam int PW = $clog2(TAG_SPACE);
  localparam logic [PW-1:0] PTR_LAST = PW'(TAG_SPACE - 1);
  localparam logic [PW-1:0] PTR_INIT = PW'(TAG_SPACE - 2);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          first_pass_r, first_pass_nxt;
  logic [ttalloc_pkg::TAG_W-1:0] ram_q;

  // fifo storage, read at head, written at tail
  ttalloc_ram #(
    .WIDTH (ttalloc_pkg::TAG_W),
    .DEPTH (TAG_SPACE)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata (cmd.push_tag),
    .re    (rd_en),
    .raddr (head_r),
    .rdata (ram_q)
  );

  // on the first pass of the head the entries still hold their reset order,
  // and the tail cannot have overtaken the head there
  always_comb begin
    if (first_pass_r && (head_r < PTR_INIT)) begin
      head_tag = ttalloc_pkg::TAG_W'(head_r) + ttalloc_pkg::TAG_W'(1);
    end else begin
      head_tag = ram_q;
    end
  end

  assign empty = (cnt_r == '0);

  // pointer and count update
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    first_pass_nxt = first_pass_r;
    if (cmd.pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PW'(1);
      cnt_nxt  = cnt_r - PW'(1);
      if (head_r == PTR_LAST) begin
        first_pass_nxt = 1'b0;
      end
    end else if (cmd.push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PW'(1);
      cnt_nxt  = cnt_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= PTR_INIT;
      cnt_r        <= PTR_INIT;
      first_pass_r <= 1'b1;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      first_pass_r <= first_pass_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/transaction_tag_allocator_top.sv
// Transaction tag allocator: hands out tags from a free FIFO, tracks pending
// tags in a bitmap RAM and checks responses. Takes ttalloc_pkg, ttalloc_ram
// and ttalloc_freelist.
//
// Each item has an accept and an execute cycle: in the accept cycle the free
// FIFO head and the pending bitmap entry of the item's tag are read from their
// RAMs, in the next cycle the result is formed and both RAMs are written back.
// The input stalls in the execute cycle, which keeps a read from ever meeting
// a write in flight, so no item is accepted while one executes. A finished
// result sits in an output register while the next item is accepted. No
// clearing pass follows reset: the FIFO's reset order is produced by the
// head pointer on its first lap, and the bitmap carries one valid flop per
// tag. Configuration (own resource) is written through cfg_wr_en/cfg_wr_data.
`default_nettype none

module transaction_tag_allocator_top #(
  parameter int TAG_SPACE = ttalloc_pkg::TAG_SPACE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [ttalloc_pkg::RES_W-1:0]    cfg_wr_data,
  // input items
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ttalloc_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [ttalloc_pkg::TAG_W-1:0]    in_tag,
  input  wire logic [ttalloc_pkg::RES_W-1:0]    in_msg_resource,
  input  wire logic                             in_finished,
  // result items
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [ttalloc_pkg::TAG_W-1:0]    out_result_tag,
  output logic      [ttalloc_pkg::STATUS_W-1:0] out_status,
  output logic                                  out_deliver,
  output logic                                  out_freed
);

  localparam int PW = $clog2(TAG_SPACE);

  logic in_acc, out_acc;

  logic [ttalloc_pkg::RES_W-1:0] own_res_r;

  logic                          exec_r, exec_nxt;
  ttalloc_pkg::mode_t            mode_r;
  logic [ttalloc_pkg::TAG_W-1:0] tag_r;
  logic [ttalloc_pkg::RES_W-1:0] res_r;
  logic                          fin_r;

  logic [TAG_SPACE-1:0] pend_vld_r;
  logic                 pend_q;
  logic                 pend_we;
  logic [PW-1:0]        pend_waddr;
  logic                 pend_wdata;
  logic [PW-1:0]        tag_idx;
  logic                 tag_in_range;
  logic                 tag_pending;

  ttalloc_pkg::fl_cmd_t          fl_cmd;
  logic [ttalloc_pkg::TAG_W-1:0] fl_head_tag;
  logic                          fl_empty;

  logic [ttalloc_pkg::TAG_W-1:0] rtag;
  ttalloc_pkg::status_t          status;
  logic                          deliver, freed;

  logic                          out_valid_r, out_valid_nxt;
  logic [ttalloc_pkg::TAG_W-1:0] out_tag_r;
  ttalloc_pkg::status_t          out_status_r;
  logic                          out_deliver_r, out_freed_r;

  // handshakes: hold off while an item is being executed or the result is stuck
  assign in_stall = exec_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_res_r <= '0;
    end else if (cfg_wr_en) begin
      own_res_r <= cfg_wr_data;
    end
  end

  // item capture
  assign exec_nxt = in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r <= 1'b0;
    end else begin
      exec_r <= exec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= ttalloc_pkg::mode_t'(in_mode);
      tag_r  <= in_tag;
      res_r  <= in_msg_resource;
      fin_r  <= in_finished;
    end
  end

  // free tag fifo
  ttalloc_freelist #(
    .TAG_SPACE (TAG_SPACE)
  ) u_freelist (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .cmd      (fl_cmd),
    .head_tag (fl_head_tag),
    .empty    (fl_empty)
  );

  // pending bitmap, read at the item's tag on accept
  ttalloc_ram #(
    .WIDTH (1),
    .DEPTH (TAG_SPACE)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (in_acc),
    .raddr (in_tag[PW-1:0]),
    .rdata (pend_q)
  );

  // an entry never written reads as not pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= '0;
    end else if (pend_we) begin
      pend_vld_r[pend_waddr] <= 1'b1;
    end
  end

  assign tag_idx      = tag_r[PW-1:0];
  assign tag_in_range = ({1'b0, tag_r} < 9'(TAG_SPACE));
  assign tag_pending  = tag_in_range && pend_vld_r[tag_idx] && pend_q;

  // execute: form result and write back fifo and bitmap
  always_comb begin
    rtag        = tag_r;
    status      = ttalloc_pkg::ST_OK;
    deliver     = 1'b0;
    freed       = 1'b0;
    fl_cmd      = '0;
    pend_we     = 1'b0;
    pend_waddr  = tag_idx;
    pend_wdata  = 1'b0;
    unique case (mode_r)
      ttalloc_pkg::MODE_ALLOC: begin
        if (fl_empty) begin
          rtag   = '0;
          status = ttalloc_pkg::ST_NO_FREE;
        end else begin
          rtag       = fl_head_tag;
          fl_cmd.pop = exec_r;
          pend_we    = exec_r;
          pend_waddr = fl_head_tag[PW-1:0];
          pend_wdata = 1'b1;
        end
      end
      ttalloc_pkg::MODE_RELEASE: begin
        if (tag_pending) begin
          freed = 1'b1;
        end else begin
          status = ttalloc_pkg::ST_NOT_PENDING;
        end
      end
      ttalloc_pkg::MODE_RESP: begin
        if (res_r != own_res_r) begin
          status = ttalloc_pkg::ST_WRONG_RES;
        end else if (!tag_pending) begin
          status = ttalloc_pkg::ST_NOT_PENDING;
        end else begin
          deliver = 1'b1;
          freed   = fin_r;
        end
      end
      default: begin
      end
    endcase
    // give the tag back to the fifo
    if (freed) begin
      fl_cmd.push     = exec_r;
      fl_cmd.push_tag = tag_r;
      pend_we         = exec_r;
      pend_waddr      = tag_idx;
      pend_wdata      = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_r) begin
      out_tag_r     <= rtag;
      out_status_r  <= status;
      out_deliver_r <= deliver;
      out_freed_r   <= freed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_tag = out_tag_r;
  assign out_status     = out_status_r;
  assign out_deliver    = out_deliver_r;
  assign out_freed      = out_freed_r;

`ifndef ASSERT_OFF
  // execute cycle is always followed by a cycle without one
  a_exec_gap: assert property (@(posedge clk) disable iff (!rst_n)
    exec_r |=> !exec_r)
    else $error("item executed in back-to-back cycles");

  // a new result only appears after an execute cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_r))
    else $error("result without executed item");

  // fifo is never popped and pushed by the same item
  a_fl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fl_cmd.pop && fl_cmd.push))
    else $error("free list pop and push together");

  // a granted tag is never one of the reserved tags
  a_grant_tag: assert property (@(posedge clk) disable iff (!rst_n)
    fl_cmd.pop |-> (fl_head_tag != '0) &&
                   (fl_head_tag != ttalloc_pkg::TAG_W'(TAG_SPACE - 1)))
    else $error("reserved tag granted");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for transaction_tag_allocator_top: a queue-fed driver,
// a scoreboarding monitor and a cycle-free model of the tag free list and pending map.
// Depends on ttalloc_pkg and the allocator RTL only.
`default_nettype none

module testbench;

  localparam int TAG_SPACE = ttalloc_pkg::TAG_SPACE_DEF;
  localparam int TAG_W     = ttalloc_pkg::TAG_W;
  localparam int RES_W     = ttalloc_pkg::RES_W;
  localparam int MODE_W    = ttalloc_pkg::MODE_W;
  localparam int STATUS_W  = ttalloc_pkg::STATUS_W;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // one request as queued by the stimulus
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [TAG_W-1:0]  tag;
    logic [RES_W-1:0]  msg_resource;
    logic              finished;
    bit                busy_tag;  // take a tag that is in use when issued
    bit                own_res;   // take the configured resource when issued
  } tag_req_t;

  // one expected result item
  typedef struct {
    logic [TAG_W-1:0]     result_tag;
    ttalloc_pkg::status_t status;
    logic                 deliver;
    logic                 freed;
  } tag_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [RES_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = ttalloc_pkg::MODE_ALLOC;
  logic [TAG_W-1:0]  in_tag = '0;
  logic [RES_W-1:0]  in_msg_resource = '0;
  logic              in_finished = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TAG_W-1:0]  out_result_tag;
  logic [STATUS_W-1:0] out_status;
  logic              out_deliver;
  logic              out_freed;

  transaction_tag_allocator_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_tag          (in_tag),
    .in_msg_resource (in_msg_resource),
    .in_finished     (in_finished),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_tag  (out_result_tag),
    .out_status      (out_status),
    .out_deliver     (out_deliver),
    .out_freed       (out_freed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // model state
  logic [TAG_W-1:0] free_ring [TAG_SPACE];
  bit               tag_busy [TAG_SPACE];
  int               ring_head, ring_tail, ring_count;
  logic [RES_W-1:0] own_res_model;

  tag_req_t    pending_reqs [$];
  tag_result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_left = 0;
  int errors = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int deliveries = 0;
  int frees = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  // model reset: ring holds 1..TAG_SPACE-2 in order, nothing in use
  function automatic void reset_tag_model();
    for (int i = 0; i < TAG_SPACE; i++) begin
      free_ring[i] = (i < TAG_SPACE - 2) ? TAG_W'(i + 1) : '0;
      tag_busy[i] = 1'b0;
    end
    ring_head = 0;
    ring_tail = TAG_SPACE - 2;
    ring_count = TAG_SPACE - 2;
    own_res_model = '0;
  endfunction

  function automatic bit tag_in_use(logic [TAG_W-1:0] t);
    return (int'(t) < TAG_SPACE) && tag_busy[t];
  endfunction

  // put a tag back at the tail of the free ring
  function automatic void return_tag(logic [TAG_W-1:0] t);
    tag_busy[t] = 1'b0;
    free_ring[ring_tail] = t;
    ring_tail = (ring_tail + 1 >= TAG_SPACE) ? 0 : ring_tail + 1;
    ring_count++;
  endfunction

  // expected outcome of one accepted request, updating the model
  function automatic tag_result_t predict_tag_op(logic [MODE_W-1:0] mode,
                                                 logic [TAG_W-1:0] tag,
                                                 logic [RES_W-1:0] res, logic fin);
    tag_result_t r;
    r.result_tag = tag;
    r.status = ttalloc_pkg::ST_OK;
    r.deliver = 1'b0;
    r.freed = 1'b0;
    if (mode == ttalloc_pkg::MODE_ALLOC) begin
      if (ring_count == 0) begin
        r.result_tag = '0;
        r.status = ttalloc_pkg::ST_NO_FREE;
      end else begin
        r.result_tag = free_ring[ring_head];
        ring_head = (ring_head + 1 >= TAG_SPACE) ? 0 : ring_head + 1;
        ring_count--;
        tag_busy[r.result_tag] = 1'b1;
      end
    end else if (mode == ttalloc_pkg::MODE_RELEASE) begin
      if (tag_in_use(tag)) begin
        return_tag(tag);
        r.freed = 1'b1;
      end else begin
        r.status = ttalloc_pkg::ST_NOT_PENDING;
      end
    end else if (mode == ttalloc_pkg::MODE_RESP) begin
      if (res != own_res_model) begin
        r.status = ttalloc_pkg::ST_WRONG_RES;
      end else if (!tag_in_use(tag)) begin
        r.status = ttalloc_pkg::ST_NOT_PENDING;
      end else begin
        r.deliver = 1'b1;
        if (fin) begin
          return_tag(tag);
          r.freed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // a random tag currently in use, or any tag when none is
  function automatic logic [TAG_W-1:0] pick_busy_tag();
    int start;
    int t;
    start = $urandom_range(TAG_SPACE - 1);
    for (int k = 0; k < TAG_SPACE; k++) begin
      t = (start + k) % TAG_SPACE;
      if (tag_busy[t]) return TAG_W'(t);
    end
    return TAG_W'($urandom);
  endfunction

  function automatic tag_req_t make_req(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                                        logic [RES_W-1:0] res, logic fin,
                                        bit busy = 0, bit own = 0);
    tag_req_t q;
    q.mode = mode;
    q.tag = tag;
    q.msg_resource = res;
    q.finished = fin;
    q.busy_tag = busy;
    q.own_res = own;
    return q;
  endfunction

  // driver: predict on accept, then offer the next item or idle
  always @(posedge clk) begin
    tag_req_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(
          predict_tag_op(in_mode, in_tag, in_msg_resource, in_finished));
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          q = pending_reqs.pop_front();
          if (q.busy_tag) q.tag = pick_busy_tag();
          if (q.own_res) q.msg_resource = own_res_model;
          in_mode <= q.mode;
          in_tag <= q.tag;
          in_msg_resource <= q.msg_resource;
          in_finished <= q.finished;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    tag_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual tag %0h status %0d",
                   $time, out_result_tag, out_status);
        end else begin
          e = expected_results.pop_front();
          check_field("result_tag", e.result_tag, out_result_tag);
          check_field("status", 8'(e.status), 8'(out_status));
          check_field("deliver", 8'(e.deliver), 8'(out_deliver));
          check_field("freed", 8'(e.freed), 8'(out_freed));
          status_seen[e.status]++;
          deliveries += int'(e.deliver);
          frees += int'(e.freed);
        end
      end
      if (recv_hold_left > 0) begin
        out_stall <= 1'b1;
        recv_hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // wait until every queued item went in and every result came out
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // write own resource while idle
  task automatic set_own_resource(logic [RES_W-1:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    own_res_model = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // random mix; alloc_pct steers the pool toward full or empty
  task automatic add_random_items(int n, int alloc_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < alloc_pct) begin
        pending_reqs.push_back(make_req(ttalloc_pkg::MODE_ALLOC, TAG_W'($urandom),
                                        RES_W'($urandom), 1'($urandom)));
      end else begin
        r = $urandom_range(99);
        if (r < 35)
          pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RELEASE, TAG_W'($urandom),
                                          RES_W'($urandom), 1'($urandom),
                                          $urandom_range(99) < 80));
        else if (r < 90)
          pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, TAG_W'($urandom),
                                          RES_W'($urandom), 1'($urandom),
                                          $urandom_range(99) < 75,
                                          $urandom_range(99) < 85));
        else if (r < 95)
          pending_reqs.push_back(make_req(MODE_UNUSED, TAG_W'($urandom),
                                          RES_W'($urandom), 1'($urandom)));
        else
          pending_reqs.push_back(make_req($urandom_range(1) ? ttalloc_pkg::MODE_RELEASE
                                                            : ttalloc_pkg::MODE_RESP,
                                          TAG_W'($urandom), RES_W'($urandom),
                                          1'($urandom)));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    reset_tag_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, own resource 0, no idling
    set_own_resource(8'h00);
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_ALLOC, 8'h00, 8'h00, 1'b0));   // gets 1
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_ALLOC, 8'hFF, 8'hFF, 1'b1));   // gets 2
    // reserved low, reserved high, never granted
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RELEASE, 8'h00, 8'h00, 1'b0));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RELEASE, 8'hFF, 8'hFF, 1'b1));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RELEASE, 8'd200, 8'h00, 1'b0));
    // wrong resource, not pending, deliver only, deliver and free, already freed
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd1, 8'd1, 1'b1));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd3, 8'h00, 1'b1));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd1, 8'h00, 1'b0));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd1, 8'h00, 1'b1));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd1, 8'h00, 1'b0));
    // free, then double release
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RELEASE, 8'd2, 8'h00, 1'b0));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RELEASE, 8'd2, 8'h00, 1'b0));
    // ignored mode, then responses to the reserved tags
    pending_reqs.push_back(make_req(MODE_UNUSED, 8'hAA, 8'h55, 1'b1));
    pending_reqs.push_back(make_req(MODE_UNUSED, 8'h55, 8'hAA, 1'b0));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'h00, 8'h00, 1'b1));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'hFF, 8'h00, 1'b1));

    // own resource at the top, then a balanced mix
    set_own_resource(8'hFF);
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_ALLOC, 8'h00, 8'h00, 1'b0));   // gets 3
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd3, 8'h00, 1'b1));     // wrong res
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd3, 8'hFF, 1'b0));
    pending_reqs.push_back(make_req(ttalloc_pkg::MODE_RESP, 8'd3, 8'hFF, 1'b1));
    add_random_items(200, 35);

    // fill the pool to empty, sender idling
    set_own_resource(8'($urandom));
    set_idling(45, 0);
    add_random_items(300, 92);

    // drain the pool, receiver stalling, with one long hold-off
    set_own_resource(8'h5A);
    set_idling(0, 45);
    add_random_items(250, 15);
    @(negedge clk);
    recv_hold_left = 300;

    // both sides idling, sender pauses until all results are back
    set_own_resource(8'h00);
    set_idling(36, 36);
    add_random_items(150, 35);
    wait_drained();
    add_random_items(150, 35);

    // no idling, random resource
    set_own_resource(8'($urandom));
    set_idling(0, 0);
    add_random_items(200, 40);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d items and %0d results over six resource settings",
             items_accepted, results_seen);
    $display("ok %0d, no free tag %0d, not pending %0d, wrong resource %0d",
             status_seen[ttalloc_pkg::ST_OK], status_seen[ttalloc_pkg::ST_NO_FREE],
             status_seen[ttalloc_pkg::ST_NOT_PENDING],
             status_seen[ttalloc_pkg::ST_WRONG_RES]);
    $display("%0d delivered, %0d freed", deliveries, frees);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire
